@@ hw/rtl/assert_macros.svh @@
// Assertion macros shared by the allocator RTL.
// Each macro clocks on clk and is disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain clocked check of a property.
`define NFA_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that an antecedent implies a consequent in the next cycle.
`define NFA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/nfa_pkg.sv @@
// Package for the next-fit id allocator: mode and status codes, defaults,
// field widths and the status struct of the slot scanner. No dependencies.
`timescale 1ns / 1ps

package nfa_pkg;

    // Default number of slots in the table.
    localparam int SLOTS_DEF = 64;

    // Field widths fixed by the interface.
    localparam int HANDLE_W = 64;
    localparam int ID_IN_W  = 8;
    localparam int ID_OUT_W = 7;

    // Request modes.
    localparam logic [1:0] MODE_ALLOC = 2'd0;
    localparam logic [1:0] MODE_FIXED = 2'd1;
    localparam logic [1:0] MODE_FREE  = 2'd2;
    localparam logic [1:0] MODE_FIND  = 2'd3;

    // Result status codes.
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_INVALID = 2'd1;
    localparam logic [1:0] ST_BUSY    = 2'd2;
    localparam logic [1:0] ST_FULL    = 2'd3;

    // Status of the slot scanner toward the sequencer.
    typedef struct packed {
        logic busy;
        logic hit;
        logic full;
    } scan_stat_t;

endpackage

@@ hw/rtl/nfa_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module nfa_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port; the data holds while no read is issued.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ hw/rtl/nfa_scan.sv @@
// Next-fit slot scanner: tests one occupied flag per cycle, starting at
// the rotating start index. Depends on nfa_pkg.
`timescale 1ns / 1ps

module nfa_scan #(
    parameter int SLOTS = nfa_pkg::SLOTS_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     go,
    input  logic [$clog2(SLOTS)-1:0] start,
    input  logic [SLOTS-1:0]         occ,
    output logic [$clog2(SLOTS)-1:0] idx,
    output nfa_pkg::scan_stat_t      stat
);

    localparam int IDW = $clog2(SLOTS);
    localparam logic [IDW-1:0] LAST = IDW'(SLOTS - 1);

    logic           busy_reg;
    logic           busy_next;
    logic [IDW-1:0] idx_reg;
    logic [IDW-1:0] idx_next;
    logic [IDW-1:0] cnt_reg;
    logic [IDW-1:0] cnt_next;
    logic           slot_free;

    // The flag test: is the slot under test free?
    assign slot_free = !occ[idx_reg];

    assign stat.busy = busy_reg;
    assign stat.hit  = busy_reg && slot_free;
    assign stat.full = busy_reg && !slot_free && (cnt_reg == LAST);
    assign idx       = idx_reg;

    // Step the index around the table until a free slot or a full lap.
    always_comb
    begin
        busy_next = busy_reg;
        idx_next  = idx_reg;
        cnt_next  = cnt_reg;
        if (go)
        begin
            busy_next = 1'b1;
            idx_next  = start;
            cnt_next  = '0;
        end
        else if (busy_reg)
        begin
            if (stat.hit || stat.full)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                idx_next = (idx_reg == LAST) ? '0 : idx_reg + 1'b1;
                cnt_next = cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
        cnt_reg <= cnt_next;
    end

endmodule

@@ hw/rtl/next_fit_id_allocator.sv @@
// Next-fit id allocator: fixed allocate, free, find and a zero-handle allocate
// go from accept to the result registers and then to the output register; allocate
// next free first runs the scanner, testing one occupied flag per cycle from the start.
// One request is in flight at a time, so the input stalls until the last result
// is in the output register; a stalled result holds off only the request after the next.
// Reset clears the occupied flags and start index; the handle RAM is not cleared.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module next_fit_id_allocator #(
    parameter int SLOTS = nfa_pkg::SLOTS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [1:0]                   mode,
    input  logic [nfa_pkg::ID_IN_W-1:0]  slot_id,
    input  logic [nfa_pkg::HANDLE_W-1:0] handle,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [1:0]                   status,
    output logic [nfa_pkg::ID_OUT_W-1:0] result_id,
    output logic [nfa_pkg::HANDLE_W-1:0] found_handle
);

    localparam int IDW = $clog2(SLOTS);
    localparam logic [IDW-1:0] LAST = IDW'(SLOTS - 1);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_RESP = 3'b100
    } state_t;

    state_t                         state_reg;
    state_t                         state_next;
    logic [SLOTS-1:0]               occ_reg;
    logic [SLOTS-1:0]               occ_next;
    logic [IDW-1:0]                 start_reg;
    logic [IDW-1:0]                 start_next;
    logic [nfa_pkg::HANDLE_W-1:0]   handle_reg;
    logic [nfa_pkg::HANDLE_W-1:0]   handle_next;
    logic [1:0]                     res_status_reg;
    logic [1:0]                     res_status_next;
    logic [nfa_pkg::ID_OUT_W-1:0]   res_id_reg;
    logic [nfa_pkg::ID_OUT_W-1:0]   res_id_next;
    logic                           use_rd_reg;
    logic                           use_rd_next;
    logic                           out_valid_reg;
    logic                           out_valid_next;
    logic [1:0]                     status_reg;
    logic [1:0]                     status_next;
    logic [nfa_pkg::ID_OUT_W-1:0]   result_id_reg;
    logic [nfa_pkg::ID_OUT_W-1:0]   result_id_next;
    logic [nfa_pkg::HANDLE_W-1:0]   found_reg;
    logic [nfa_pkg::HANDLE_W-1:0]   found_next;

    logic                           in_accept;
    logic                           out_free;
    logic                           id_ok;
    logic                           handle_zero;
    logic [IDW-1:0]                 slot_idx;
    logic                           scan_go;
    logic [IDW-1:0]                 scan_idx;
    nfa_pkg::scan_stat_t            scan_stat;
    logic                           ram_we;
    logic [IDW-1:0]                 ram_waddr;
    logic [nfa_pkg::HANDLE_W-1:0]   ram_wdata;
    logic                           ram_re;
    logic [nfa_pkg::HANDLE_W-1:0]   ram_rdata;
    logic                           out_fail;
    logic                           out_data_zero;

    // Handshake and argument checks.
    assign in_stall    = (state_reg != S_IDLE);
    assign in_accept   = in_valid && !in_stall;
    assign out_free    = !out_valid_reg || !out_stall;
    assign id_ok       = slot_id < nfa_pkg::ID_IN_W'(SLOTS);
    assign handle_zero = (handle == '0);
    assign slot_idx    = slot_id[IDW-1:0];

    // Handle storage.
    nfa_ram #(
        .WIDTH (nfa_pkg::HANDLE_W),
        .DEPTH (SLOTS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (slot_idx),
        .rdata (ram_rdata)
    );

    // Next-fit scanner over the occupied flags.
    nfa_scan #(
        .SLOTS (SLOTS)
    ) u_scan (
        .clk   (clk),
        .rst_n (rst_n),
        .go    (scan_go),
        .start (start_reg),
        .occ   (occ_reg),
        .idx   (scan_idx),
        .stat  (scan_stat)
    );

    // Request sequencer.
    always_comb
    begin
        state_next      = state_reg;
        occ_next        = occ_reg;
        start_next      = start_reg;
        handle_next     = handle_reg;
        res_status_next = res_status_reg;
        res_id_next     = res_id_reg;
        use_rd_next     = use_rd_reg;
        out_valid_next  = out_valid_reg && out_stall;
        status_next     = status_reg;
        result_id_next  = result_id_reg;
        found_next      = found_reg;
        scan_go         = 1'b0;
        ram_we          = 1'b0;
        ram_waddr       = slot_idx;
        ram_wdata       = handle;
        ram_re          = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    state_next      = S_RESP;
                    res_status_next = nfa_pkg::ST_OK;
                    res_id_next     = '0;
                    use_rd_next     = 1'b0;
                    case (mode)
                        nfa_pkg::MODE_ALLOC:
                        begin
                            if (handle_zero)
                            begin
                                res_status_next = nfa_pkg::ST_INVALID;
                            end
                            else
                            begin
                                scan_go     = 1'b1;
                                handle_next = handle;
                                state_next  = S_SCAN;
                            end
                        end
                        nfa_pkg::MODE_FIXED:
                        begin
                            if (handle_zero || !id_ok)
                            begin
                                res_status_next = nfa_pkg::ST_INVALID;
                            end
                            else if (occ_reg[slot_idx])
                            begin
                                res_status_next = nfa_pkg::ST_BUSY;
                            end
                            else
                            begin
                                ram_we             = 1'b1;
                                occ_next[slot_idx] = 1'b1;
                                res_id_next        = nfa_pkg::ID_OUT_W'(slot_idx);
                            end
                        end
                        nfa_pkg::MODE_FREE:
                        begin
                            if (!id_ok)
                            begin
                                res_status_next = nfa_pkg::ST_INVALID;
                            end
                            else
                            begin
                                occ_next[slot_idx] = 1'b0;
                            end
                        end
                        default:
                        begin
                            // Find: read the handle only behind a set flag.
                            if (!id_ok)
                            begin
                                res_status_next = nfa_pkg::ST_INVALID;
                            end
                            else if (occ_reg[slot_idx])
                            begin
                                ram_re      = 1'b1;
                                use_rd_next = 1'b1;
                            end
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                if (scan_stat.hit)
                begin
                    ram_we             = 1'b1;
                    ram_waddr          = scan_idx;
                    ram_wdata          = handle_reg;
                    occ_next[scan_idx] = 1'b1;
                    start_next         = (scan_idx == LAST) ? '0 : scan_idx + 1'b1;
                    res_status_next    = nfa_pkg::ST_OK;
                    res_id_next        = nfa_pkg::ID_OUT_W'(scan_idx);
                    state_next         = S_RESP;
                end
                else if (scan_stat.full)
                begin
                    res_status_next = nfa_pkg::ST_FULL;
                    state_next      = S_RESP;
                end
            end
            S_RESP:
            begin
                // Move the result into the output register once it is free.
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    status_next    = res_status_reg;
                    result_id_next = res_id_reg;
                    found_next     = use_rd_reg ? ram_rdata : '0;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            occ_reg       <= '0;
            start_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            occ_reg       <= occ_next;
            start_reg     <= start_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        handle_reg     <= handle_next;
        res_status_reg <= res_status_next;
        res_id_reg     <= res_id_next;
        use_rd_reg     <= use_rd_next;
        status_reg     <= status_next;
        result_id_reg  <= result_id_next;
        found_reg      <= found_next;
    end

    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign result_id    = result_id_reg;
    assign found_handle = found_reg;

    // Conditions on the output register used by the result check.
    assign out_fail      = out_valid_reg && (status_reg != nfa_pkg::ST_OK);
    assign out_data_zero = (result_id_reg == '0) && (found_reg == '0);

    // A full report only comes with every flag set.
    `NFA_ASSERT(a_full_all_used, !scan_stat.full || (&occ_reg), "table full with a free slot")
    // A slot found by the scanner is marked used on the next cycle.
    `NFA_ASSERT_NEXT(a_hit_marks, scan_stat.hit, occ_reg[$past(scan_idx)], "slot not marked")
    // The scanner runs exactly while the sequencer waits for it.
    `NFA_ASSERT(a_scan_state, (state_reg == S_SCAN) == scan_stat.busy, "scan state mismatch")
    // Failed requests carry no id and no handle.
    `NFA_ASSERT(a_fail_zero, !out_fail || out_data_zero, "failed result carries data")

endmodule
